// File: design/fpfa_pkg.sv
package fpfa_pkg;

    // Table geometry
    localparam int MAX_PARTITIONS = 16;
    localparam int SPACE_BITS     = 16;
    localparam int ID_W           = 16;
    localparam int IDX_W          = $clog2(MAX_PARTITIONS);
    localparam int CNT_W          = IDX_W + 1;
    localparam int META_W         = ID_W + SPACE_BITS;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int POLICY_W   = 2;
    localparam int ACT_W      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BLOCKS = 2'd1;

    // Commands
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RESTORE = 2'd2;

    // Fit policies; the unused code acts as first fit
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    // Control from the sequencer to the candidate picker
    typedef struct packed {
        logic                  clear;
        logic                  valid;
        logic [POLICY_W-1:0]   policy;
        logic [SPACE_BITS-1:0] req;
        logic [IDX_W-1:0]      idx;
        logic [ID_W-1:0]       id;
        logic [SPACE_BITS-1:0] free;
    } pick_ctl_t;

    // Current choice held by the picker
    typedef struct packed {
        logic                  found;
        logic [IDX_W-1:0]      idx;
        logic [ID_W-1:0]       id;
        logic [SPACE_BITS-1:0] free;
    } pick_res_t;

endpackage

// File: design/fpfa_ram.sv
// Single write port, single read port, registered read data
module fpfa_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/fpfa_pick.sv
// Keeps the best candidate seen so far during a table scan
module fpfa_pick
    import fpfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pick_ctl_t ctl,
    output pick_res_t res
);

    logic                  found_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [ID_W-1:0]       id_reg;
    logic [SPACE_BITS-1:0] free_reg;
    logic                  fits;
    logic                  better;
    logic                  take;

    // Candidate test; once found, first fit never replaces
    always_comb
    begin
        fits = (ctl.free >= ctl.req);
        case (ctl.policy)
            POLICY_BEST:  better = (ctl.free < free_reg);
            POLICY_WORST: better = (ctl.free > free_reg);
            default:      better = 1'b0;
        endcase
        take = ctl.valid && fits && (!found_reg || better);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            idx_reg  <= ctl.idx;
            id_reg   <= ctl.id;
            free_reg <= ctl.free;
        end
    end

    assign res.found = found_reg;
    assign res.idx   = idx_reg;
    assign res.id    = id_reg;
    assign res.free  = free_reg;

endmodule

// File: design/fixed_partition_fit_allocator.sv
// Load: no result. Restore: one table entry per cycle.
// Allocate over n active entries: the scan reads the free and meta memories at
// one entry per cycle. One item at a time; the next item is taken once the
// current one is done.
// rst_n (async, active low) clears control and configuration; table
// contents are undefined until loaded.
module fixed_partition_fit_allocator
    import fpfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // item input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic [IDX_W-1:0]      entry_index,
    input  logic [ID_W-1:0]       entry_id,
    input  logic [SPACE_BITS-1:0] entry_total,
    input  logic [SPACE_BITS-1:0] entry_free,
    input  logic [SPACE_BITS-1:0] request_size,
    // result output
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  granted,
    output logic [ID_W-1:0]       granted_id,
    output logic [IDX_W-1:0]      granted_index,
    output logic [SPACE_BITS-1:0] space_left,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESTORE
    } state_t;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTITIONS);

    state_t                state_reg,     state_next;
    logic [CNT_W-1:0]      cnt_reg,       cnt_next;
    logic [CNT_W-1:0]      n_reg,         n_next;
    logic                  rd_vld_reg,    rd_vld_next;
    logic [IDX_W-1:0]      rd_idx_reg,    rd_idx_next;
    logic [SPACE_BITS-1:0] req_reg,       req_next;
    logic [POLICY_W-1:0]   policy_reg,    policy_next;
    logic [ACT_W-1:0]      active_reg,    active_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  granted_reg,   granted_next;
    logic [ID_W-1:0]       gid_reg,       gid_next;
    logic [IDX_W-1:0]      gidx_reg,      gidx_next;
    logic [SPACE_BITS-1:0] left_reg,      left_next;

    // memory ports
    logic                  meta_we;
    logic                  free_we;
    logic [IDX_W-1:0]      free_waddr;
    logic [SPACE_BITS-1:0] free_wdata;
    logic                  rd_en;
    logic [META_W-1:0]     meta_rdata;
    logic [SPACE_BITS-1:0] free_rdata;

    pick_ctl_t             pick_ctl;
    pick_res_t             pick_res;
    logic [SPACE_BITS-1:0] remain;

    fpfa_ram #(
        .WIDTH (META_W),
        .DEPTH (MAX_PARTITIONS)
    ) u_meta_ram (
        .clk     (clk),
        .we      (meta_we),
        .wr_addr (entry_index),
        .wr_data ({entry_id, entry_total}),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (meta_rdata)
    );

    fpfa_ram #(
        .WIDTH (SPACE_BITS),
        .DEPTH (MAX_PARTITIONS)
    ) u_free_ram (
        .clk     (clk),
        .we      (free_we),
        .wr_addr (free_waddr),
        .wr_data (free_wdata),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (free_rdata)
    );

    // Candidate picker sees read data in the cycle after the address
    always_comb
    begin
        pick_ctl.clear  = 1'b0;
        pick_ctl.valid  = rd_vld_reg && (state_reg == ST_SCAN);
        pick_ctl.policy = policy_reg;
        pick_ctl.req    = req_reg;
        pick_ctl.idx    = rd_idx_reg;
        pick_ctl.id     = meta_rdata[META_W-1:SPACE_BITS];
        pick_ctl.free   = free_rdata;
        if ((state_reg == ST_IDLE) && in_valid && (command == CMD_ALLOC))
        begin
            pick_ctl.clear = 1'b1;
        end
    end

    fpfa_pick u_pick (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pick_ctl),
        .res   (pick_res)
    );

    assign remain    = pick_res.free - req_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Sequencer next-state and memory control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        req_next       = req_reg;
        policy_next    = policy_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        granted_next   = granted_reg;
        gid_next       = gid_reg;
        gidx_next      = gidx_reg;
        left_next      = left_reg;
        meta_we        = 1'b0;
        free_we        = 1'b0;
        free_waddr     = entry_index;
        free_wdata     = entry_free;
        rd_en          = 1'b0;

        // configuration
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FIT_POLICY:    policy_next = cfg_data[POLICY_W-1:0];
                CFG_ACTIVE_BLOCKS: active_next = cfg_data[ACT_W-1:0];
                default:           ;
            endcase
        end

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (command)
                        CMD_LOAD:
                        begin
                            meta_we = 1'b1;
                            free_we = 1'b1;
                        end
                        CMD_ALLOC:
                        begin
                            req_next   = request_size;
                            cnt_next   = '0;
                            n_next     = (CNT_W'(active_reg) > MAX_CNT) ? MAX_CNT
                                                                       : CNT_W'(active_reg);
                            state_next = ST_SCAN;
                        end
                        CMD_RESTORE:
                        begin
                            cnt_next   = '0;
                            state_next = ST_RESTORE;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (cnt_reg < n_reg)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = pick_res.found;
                    if (pick_res.found)
                    begin
                        gid_next   = pick_res.id;
                        gidx_next  = pick_res.idx;
                        left_next  = remain;
                        free_we    = 1'b1;
                        free_waddr = pick_res.idx;
                        free_wdata = remain;
                    end
                    else
                    begin
                        gid_next  = '0;
                        gidx_next = '0;
                        left_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_RESTORE:
            begin
                if (cnt_reg < MAX_CNT)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                // copy total into free one entry behind the read
                if (rd_vld_reg)
                begin
                    free_we    = 1'b1;
                    free_waddr = rd_idx_reg;
                    free_wdata = meta_rdata[SPACE_BITS-1:0];
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            req_reg       <= '0;
            policy_reg    <= POLICY_FIRST;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
            granted_reg   <= 1'b0;
            gid_reg       <= '0;
            gidx_reg      <= '0;
            left_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            rd_vld_reg    <= rd_vld_next;
            rd_idx_reg    <= rd_idx_next;
            req_reg       <= req_next;
            policy_reg    <= policy_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            granted_reg   <= granted_next;
            gid_reg       <= gid_next;
            gidx_reg      <= gidx_next;
            left_reg      <= left_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign granted_id    = gid_reg;
    assign granted_index = gidx_reg;
    assign space_left    = left_reg;

endmodule
